// File: hdl/tvla_pkg.sv
// Shared constants and codes for the thrust vector limiter and attitude setpoint block.
package tvla_pkg;

    localparam int HEAD_W    = 15;
    localparam int ANG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int UP_FLOOR  = 2048;
    localparam int TAB_LEN   = 24;

    // Angles below are in units of 2^-24 rad.
    localparam int PI_Q24      = 52707179;
    localparam int TWO_PI_Q24  = 105414357;
    localparam int HALF_PI_Q24 = 26353589;
    localparam int INV_GAIN_Q30 = 652032874;

    localparam logic [23:0] ATAN_TAB [TAB_LEN] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_THRUST     = 4'd0,
        CFG_RETURN_LIMITED = 4'd1
    } cfg_index_t;

endpackage

// File: hdl/thrust_vector_limit_attitude_top.sv
// Thrust vector limiter with tilt-angle setpoint, as one deep pipeline.
//
// One transaction enters per cycle unless the result side stalls. The depth is set by the
// bit-per-stage square roots (two of FORCE_WIDTH stages), the bit-per-stage divider
// (FORCE_WIDTH-1 stages) and the two CORDIC chains (CORDIC_STEPS stages each). When the
// result side stalls, the whole pipeline holds and s_tready falls; nothing is dropped or
// repeated. Write the configuration only while the pipeline is empty.
module thrust_vector_limit_attitude_top #(
    parameter int FORCE_WIDTH  = 20,
    parameter int CORDIC_STEPS = 16,
    localparam int IN_TDW  = ((3 * FORCE_WIDTH + tvla_pkg::HEAD_W + 7) / 8) * 8,
    localparam int OUT_TDW = ((2 * tvla_pkg::ANG_W + 4 * FORCE_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // force_north, force_east, force_up, heading (lowest bits first)
    input  logic [IN_TDW-1:0]                 s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pitch_angle, roll_angle, thrust_out, out_north, out_east, out_up (lowest bits first)
    output logic [OUT_TDW-1:0]                m_tdata,
    // was_limited
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tvla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [FORCE_WIDTH-2:0]            cfg_data
);
    import tvla_pkg::*;

    localparam int W   = FORCE_WIDTH;
    localparam int CS  = CORDIC_STEPS;
    localparam int MW  = W - 1;
    localparam int SW  = 2 * W;
    localparam int RW  = W + 2;
    localparam int CW  = 36;
    localparam int ZW  = 30;
    localparam int GW  = 32;
    localparam int PRW = 64;

    localparam int ST_SQ   = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_RT0  = 2;
    localparam int ST_MUL  = ST_RT0 + W;
    localparam int ST_DV0  = ST_MUL + 1;
    localparam int ST_SEL  = ST_DV0 + W - 1;
    localparam int ST_SQ2  = ST_SEL + 1;
    localparam int ST_SUM2 = ST_SQ2 + 1;
    localparam int ST_TR0  = ST_SUM2 + 1;
    localparam int ST_NM0  = ST_TR0 + W;
    localparam int ST_VC0  = ST_NM0 + 5;
    localparam int ST_ANG  = ST_VC0 + CS;
    localparam int ST_RC0  = ST_ANG + 1;
    localparam int ST_GN   = ST_RC0 + CS;
    localparam int ST_OUT  = ST_GN + 1;
    localparam int NST     = ST_OUT + 1;

    localparam logic signed [W:0]     UP_MIN    = (W + 1)'(UP_FLOOR);
    localparam logic signed [ZW-1:0]  Z_PI      = ZW'(PI_Q24);
    localparam logic signed [ZW-1:0]  Z_TWO_PI  = ZW'(TWO_PI_Q24);
    localparam logic signed [ZW-1:0]  Z_HALF_PI = ZW'(HALF_PI_Q24);
    localparam logic signed [ZW-1:0]  Z_RND     = ZW'(2048);
    localparam logic signed [GW-1:0]  G_INV     = GW'(INV_GAIN_Q30);
    localparam logic signed [PRW-1:0] G_RND     = PRW'(64'sd1 <<< 41);

    typedef struct packed {
        logic [SW-1:0] v;
        logic [RW-1:0] r;
        logic [W-1:0]  q;
    } sq_t;

    typedef struct packed {
        logic [SW-1:0] p;
        logic [W-1:0]  q;
    } dv_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [31:0]          m;
    } cd_t;

    typedef struct packed {
        logic signed [W-1:0]     n0, e0, u0;
        logic signed [W-1:0]     n, e;
        logic signed [W:0]       u;
        logic                    lim, over, up_over, flip;
        logic signed [ZW-1:0]    hz;
        logic [SW-1:0]           nn, ee, uu, mxsq;
        sq_t                     sqa, sqb;
        dv_t                     dva, dvb;
        cd_t                     cda, cdb;
        logic signed [PRW-1:0]   gx, gy;
        logic signed [ANG_W-1:0] pitch, roll;
    } rec_t;

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        t = (W + 1)'(v);
        if (v < 0) begin
            t = -t;
        end
        return t[W-1:0];
    endfunction

    // One result bit of a floor square root.
    function automatic sq_t sq_step(input sq_t a);
        logic [RW+1:0] trial;
        logic [RW+1:0] tq;
        sq_t           o;
        trial = {a.r, a.v[SW-1:SW-2]};
        tq    = {2'b00, a.q, 2'b01};
        o.v   = {a.v[SW-3:0], 2'b00};
        if (trial >= tq) begin
            o.r = RW'(trial - tq);
            o.q = {a.q[W-2:0], 1'b1};
        end else begin
            o.r = trial[RW-1:0];
            o.q = {a.q[W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of a restoring division.
    function automatic dv_t dv_step(input dv_t a, input logic [W-1:0] den, input int s);
        logic [SW-1:0] d;
        dv_t           o;
        d = SW'(den) << s;
        o = a;
        if (a.p >= d) begin
            o.p = a.p - d;
            o.q = a.q | (W'(1) << s);
        end
        return o;
    endfunction

    function automatic cd_t nm_init(input logic signed [W-1:0] y, input logic signed [W:0] x);
        logic [31:0] ym;
        logic [31:0] xm;
        cd_t         o;
        ym  = 32'(mag_w(y));
        xm  = 32'(x[W-1:0]);
        o.x = CW'(x);
        o.y = CW'(y);
        o.z = '0;
        o.m = (ym > xm) ? ym : xm;
        return o;
    endfunction

    // Doubling steps until the larger magnitude reaches bit 30.
    function automatic cd_t nm_step(input cd_t a, input int s);
        cd_t o;
        o = a;
        if (a.m < (32'd1 << (31 - s))) begin
            o.x = a.x <<< s;
            o.y = a.y <<< s;
            o.m = a.m << s;
        end
        return o;
    endfunction

    function automatic cd_t vc_step(input cd_t a, input int i);
        cd_t o;
        o = a;
        if (!a.y[CW-1]) begin
            o.x = a.x + (a.y >>> i);
            o.y = a.y - (a.x >>> i);
            o.z = a.z + $signed(ZW'(ATAN_TAB[i]));
        end else begin
            o.x = a.x - (a.y >>> i);
            o.y = a.y + (a.x >>> i);
            o.z = a.z - $signed(ZW'(ATAN_TAB[i]));
        end
        return o;
    endfunction

    function automatic cd_t rc_step(input cd_t a, input int i);
        cd_t o;
        o = a;
        if (!a.z[ZW-1]) begin
            o.x = a.x - (a.y >>> i);
            o.y = a.y + (a.x >>> i);
            o.z = a.z - $signed(ZW'(ATAN_TAB[i]));
        end else begin
            o.x = a.x + (a.y >>> i);
            o.y = a.y - (a.x >>> i);
            o.z = a.z + $signed(ZW'(ATAN_TAB[i]));
        end
        return o;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [PRW-1:0] v);
        logic signed [PRW-1:0] hi;
        logic signed [PRW-1:0] lo;
        hi = PRW'((64'sd1 <<< (ANG_W - 1)) - 64'sd1);
        lo = -hi - PRW'(64'sd1);
        if (v > hi) begin
            return ANG_W'(hi);
        end else if (v < lo) begin
            return ANG_W'(lo);
        end
        return ANG_W'(v);
    endfunction

    logic [MW-1:0]       max_thrust_reg;
    logic                ret_limited_reg;
    rec_t                pipe_reg  [NST];
    rec_t                pipe_next [NST];
    logic [NST-1:0]      vld_reg;
    logic [NST-1:0]      vld_next;
    logic                en;
    logic signed [W-1:0] in_n, in_e, in_u;
    logic signed [HEAD_W-1:0] in_head;

    assign in_n    = s_tdata[0 +: W];
    assign in_e    = s_tdata[W +: W];
    assign in_u    = s_tdata[2*W +: W];
    assign in_head = s_tdata[3*W +: HEAD_W];

    // The output stage is the last pipeline register; a stall there freezes every stage.
    assign en        = !vld_reg[NST-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_thrust_reg  <= '0;
            ret_limited_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_THRUST:     max_thrust_reg  <= cfg_data;
                CFG_RETURN_LIMITED: ret_limited_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_st
            if (k == ST_SQ) begin : g_sq
                always_comb begin
                    logic signed [ZW-1:0] zh;
                    logic                 low;
                    logic [W-1:0]         ufl;
                    pipe_next[k]    = '0;
                    low             = ((W + 1)'(in_u) < UP_MIN);
                    ufl             = low ? W'(UP_FLOOR) : in_u;
                    pipe_next[k].n0 = in_n;
                    pipe_next[k].e0 = in_e;
                    pipe_next[k].u0 = in_u;
                    pipe_next[k].n  = in_n;
                    pipe_next[k].e  = in_e;
                    pipe_next[k].u  = low ? UP_MIN : (W + 1)'(in_u);
                    pipe_next[k].lim  = low;
                    pipe_next[k].nn   = mag_w(in_n) * mag_w(in_n);
                    pipe_next[k].ee   = mag_w(in_e) * mag_w(in_e);
                    pipe_next[k].uu   = ufl * ufl;
                    pipe_next[k].mxsq = max_thrust_reg * max_thrust_reg;
                    // Yaw goes in negated and wrapped into plus or minus pi.
                    zh = -(ZW'(in_head) <<< 12);
                    if (zh > Z_PI) begin
                        zh = zh - Z_TWO_PI;
                    end else if (zh < -Z_PI) begin
                        zh = zh + Z_TWO_PI;
                    end
                    pipe_next[k].hz = zh;
                end
            end else if (k == ST_SUM) begin : g_sum
                always_comb begin
                    logic [SW-1:0] sum3;
                    pipe_next[k]   = pipe_reg[k-1];
                    sum3 = pipe_reg[k-1].nn + pipe_reg[k-1].ee + pipe_reg[k-1].uu;
                    pipe_next[k].over    = (sum3 > pipe_reg[k-1].mxsq);
                    pipe_next[k].up_over = (pipe_reg[k-1].u > (W + 1)'(max_thrust_reg));
                    pipe_next[k].sqa.v   = pipe_reg[k-1].mxsq - pipe_reg[k-1].uu;
                    pipe_next[k].sqa.r   = '0;
                    pipe_next[k].sqa.q   = '0;
                    pipe_next[k].sqb.v   = pipe_reg[k-1].nn + pipe_reg[k-1].ee;
                    pipe_next[k].sqb.r   = '0;
                    pipe_next[k].sqb.q   = '0;
                    // Fold into plus or minus pi/2; the rotated result is negated later.
                    if (pipe_reg[k-1].hz > Z_HALF_PI) begin
                        pipe_next[k].hz   = pipe_reg[k-1].hz - Z_PI;
                        pipe_next[k].flip = 1'b1;
                    end else if (pipe_reg[k-1].hz < -Z_HALF_PI) begin
                        pipe_next[k].hz   = pipe_reg[k-1].hz + Z_PI;
                        pipe_next[k].flip = 1'b1;
                    end else begin
                        pipe_next[k].flip = 1'b0;
                    end
                end
            end else if (k >= ST_RT0 && k < ST_MUL) begin : g_rt
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].sqa = sq_step(pipe_reg[k-1].sqa);
                    pipe_next[k].sqb = sq_step(pipe_reg[k-1].sqb);
                end
            end else if (k == ST_MUL) begin : g_mul
                always_comb begin
                    pipe_next[k]       = pipe_reg[k-1];
                    pipe_next[k].dva.p = mag_w(pipe_reg[k-1].n) * pipe_reg[k-1].sqa.q;
                    pipe_next[k].dva.q = '0;
                    pipe_next[k].dvb.p = mag_w(pipe_reg[k-1].e) * pipe_reg[k-1].sqa.q;
                    pipe_next[k].dvb.q = '0;
                end
            end else if (k >= ST_DV0 && k < ST_SEL) begin : g_dv
                localparam int S = W - 2 - (k - ST_DV0);
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].dva = dv_step(pipe_reg[k-1].dva, pipe_reg[k-1].sqb.q, S);
                    pipe_next[k].dvb = dv_step(pipe_reg[k-1].dvb, pipe_reg[k-1].sqb.q, S);
                end
            end else if (k == ST_SEL) begin : g_sel
                always_comb begin
                    pipe_next[k] = pipe_reg[k-1];
                    if (pipe_reg[k-1].over) begin
                        pipe_next[k].lim = 1'b1;
                        if (pipe_reg[k-1].up_over) begin
                            pipe_next[k].n = '0;
                            pipe_next[k].e = '0;
                            pipe_next[k].u = (W + 1)'(max_thrust_reg);
                        end else if (pipe_reg[k-1].sqb.q == '0) begin
                            pipe_next[k].n = '0;
                            pipe_next[k].e = '0;
                        end else begin
                            pipe_next[k].n = pipe_reg[k-1].n[W-1] ?
                                -$signed(pipe_reg[k-1].dva.q) : $signed(pipe_reg[k-1].dva.q);
                            pipe_next[k].e = pipe_reg[k-1].e[W-1] ?
                                -$signed(pipe_reg[k-1].dvb.q) : $signed(pipe_reg[k-1].dvb.q);
                        end
                    end
                end
            end else if (k == ST_SQ2) begin : g_sq2
                always_comb begin
                    pipe_next[k]    = pipe_reg[k-1];
                    pipe_next[k].nn = mag_w(pipe_reg[k-1].n) * mag_w(pipe_reg[k-1].n);
                    pipe_next[k].ee = mag_w(pipe_reg[k-1].e) * mag_w(pipe_reg[k-1].e);
                    pipe_next[k].uu = pipe_reg[k-1].u[W-1:0] * pipe_reg[k-1].u[W-1:0];
                end
            end else if (k == ST_SUM2) begin : g_sum2
                always_comb begin
                    pipe_next[k]       = pipe_reg[k-1];
                    pipe_next[k].sqa.v = pipe_reg[k-1].nn + pipe_reg[k-1].ee + pipe_reg[k-1].uu;
                    pipe_next[k].sqa.r = '0;
                    pipe_next[k].sqa.q = '0;
                end
            end else if (k >= ST_TR0 && k < ST_NM0) begin : g_tr
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].sqa = sq_step(pipe_reg[k-1].sqa);
                end
            end else if (k == ST_NM0) begin : g_nm0
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].cda = nm_step(nm_init(pipe_reg[k-1].n, pipe_reg[k-1].u), 16);
                    pipe_next[k].cdb = nm_step(nm_init(pipe_reg[k-1].e, pipe_reg[k-1].u), 16);
                end
            end else if (k > ST_NM0 && k < ST_VC0) begin : g_nm
                localparam int S = 16 >> (k - ST_NM0);
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].cda = nm_step(pipe_reg[k-1].cda, S);
                    pipe_next[k].cdb = nm_step(pipe_reg[k-1].cdb, S);
                end
            end else if (k >= ST_VC0 && k < ST_ANG) begin : g_vc
                localparam int I = k - ST_VC0;
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].cda = vc_step(pipe_reg[k-1].cda, I);
                    pipe_next[k].cdb = vc_step(pipe_reg[k-1].cdb, I);
                end
            end else if (k == ST_ANG) begin : g_ang
                always_comb begin
                    logic signed [ZW-1:0] za;
                    logic signed [ZW-1:0] zb;
                    za = (pipe_reg[k-1].cda.z + Z_RND) >>> 12;
                    zb = (pipe_reg[k-1].cdb.z + Z_RND) >>> 12;
                    pipe_next[k] = pipe_reg[k-1];
                    // Without a positive up force both tilt angles are zero.
                    if (pipe_reg[k-1].u > 0) begin
                        pipe_next[k].cda.x = CW'(za) <<< 12;
                        pipe_next[k].cda.y = CW'(zb) <<< 12;
                    end else begin
                        pipe_next[k].cda.x = '0;
                        pipe_next[k].cda.y = '0;
                    end
                    pipe_next[k].cda.z = pipe_reg[k-1].hz;
                end
            end else if (k >= ST_RC0 && k < ST_GN) begin : g_rc
                localparam int I = k - ST_RC0;
                always_comb begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].cda = rc_step(pipe_reg[k-1].cda, I);
                end
            end else if (k == ST_GN) begin : g_gn
                always_comb begin
                    pipe_next[k]    = pipe_reg[k-1];
                    pipe_next[k].gx = $signed(pipe_reg[k-1].cda.x[GW-1:0]) * G_INV;
                    pipe_next[k].gy = $signed(pipe_reg[k-1].cda.y[GW-1:0]) * G_INV;
                end
            end else begin : g_out
                always_comb begin
                    logic signed [PRW-1:0] tx;
                    logic signed [PRW-1:0] ty;
                    logic signed [W:0]     u_hi;
                    tx   = (pipe_reg[k-1].gx + G_RND) >>> 42;
                    ty   = (pipe_reg[k-1].gy + G_RND) >>> 42;
                    u_hi = (W + 1)'((W + 1)'(1) << (W - 1)) - (W + 1)'(1);
                    if (pipe_reg[k-1].flip) begin
                        tx = -tx;
                        ty = -ty;
                    end
                    pipe_next[k]       = pipe_reg[k-1];
                    pipe_next[k].pitch = sat_ang(tx);
                    pipe_next[k].roll  = sat_ang(ty);
                    if (!ret_limited_reg) begin
                        pipe_next[k].n = pipe_reg[k-1].n0;
                        pipe_next[k].e = pipe_reg[k-1].e0;
                        pipe_next[k].u = (W + 1)'(pipe_reg[k-1].u0);
                    end else if (pipe_reg[k-1].u > u_hi) begin
                        pipe_next[k].u = u_hi;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OUT_TDW'({pipe_reg[NST-1].u[W-1:0], pipe_reg[NST-1].e,
                                pipe_reg[NST-1].n, pipe_reg[NST-1].sqa.q,
                                pipe_reg[NST-1].roll, pipe_reg[NST-1].pitch});
    assign m_tuser  = pipe_reg[NST-1].lim;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_zero_thrust_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2*ANG_W +: W] == '0) |->
            (m_tdata[0 +: ANG_W] == '0) && (m_tdata[ANG_W +: ANG_W] == '0))
        else $error("zero thrust gave nonzero tilt angles");

endmodule

// File: tb/sv/thrust_vector_limit_attitude_top_tb.sv
// Self-checking testbench for the thrust vector limiter and attitude setpoint block.
`timescale 1ns / 1ps

module thrust_vector_limit_attitude_top_tb;
    import tvla_pkg::*;

    localparam int FW      = 20;
    localparam int STEPS   = 16;
    localparam int IN_TDW  = ((3 * FW + HEAD_W + 7) / 8) * 8;
    localparam int OUT_TDW = ((2 * ANG_W + 4 * FW + 7) / 8) * 8;
    localparam int LATENCY = 3 * FW + 2 * STEPS + 13;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic signed [FW-1:0]     up;
        logic signed [FW-1:0]     east;
        logic signed [FW-1:0]     north;
    } force_cmd_t;

    typedef struct {
        logic [ANG_W-1:0] pitch;
        logic [ANG_W-1:0] roll;
        logic [FW-1:0]    thrust;
        logic [FW-1:0]    north;
        logic [FW-1:0]    east;
        logic [FW-1:0]    up;
        logic             limited;
    } setpoint_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_TDW-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_TDW-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FW-2:0]      cfg_data = '0;

    thrust_vector_limit_attitude_top #(.FORCE_WIDTH(FW), .CORDIC_STEPS(STEPS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the registers.
    longint unsigned lim_max;
    bit              lim_writeback;

    setpoint_t expected_setpoints[$];
    int  error_count;
    int  result_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_sink;
    longint cycle_count;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp_signed(longint v, int w);
        longint hi = (64'sd1 <<< (w - 1)) - 1;
        longint lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint tilt_atan(longint y, longint x);
        longint z = 0;
        longint nx, ny;
        longint m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        while (m < (64'sd1 <<< 30)) begin
            x *= 2;
            y *= 2;
            m <<= 1;
        end
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return shr_floor(z + 2048, 12);
    endfunction

    function automatic setpoint_t predict_setpoint(force_cmd_t c);
        setpoint_t r;
        longint n0 = c.north, e0 = c.east, u0 = c.up, hd = c.heading;
        longint n = n0, e = e0, u = u0;
        longint ax = 0, ay = 0, z, x, y, nx, ny;
        longint unsigned nn, ee, uu, rem, len, thr;
        longint unsigned mx = lim_max;
        bit lim = 0;
        bit flip = 0;
        if (u < UP_FLOOR) begin
            u = UP_FLOOR;
            lim = 1;
        end
        nn = abs64(n) * abs64(n);
        ee = abs64(e) * abs64(e);
        uu = abs64(u) * abs64(u);
        if (nn + ee + uu > mx * mx) begin
            lim = 1;
            if (longint'(u) > longint'(mx)) begin
                n = 0;
                e = 0;
                u = mx;
            end else begin
                rem = int_sqrt(mx * mx - uu);
                len = int_sqrt(nn + ee);
                if (len == 0) begin
                    n = 0;
                    e = 0;
                end else begin
                    n = (n < 0) ? -longint'(abs64(n) * rem / len) : longint'(n * rem / len);
                    e = (e < 0) ? -longint'(abs64(e) * rem / len) : longint'(e * rem / len);
                end
            end
        end
        thr = int_sqrt(abs64(n) * abs64(n) + abs64(e) * abs64(e) + abs64(u) * abs64(u));
        if (thr > (64'd1 << FW) - 1) thr = (64'd1 << FW) - 1;
        if (u > 0) begin
            ax = tilt_atan(n, u);
            ay = tilt_atan(e, u);
        end
        // Body-frame rotation by minus the heading, folded into the CORDIC range.
        z = -hd * 4096;
        x = ax * 4096;
        y = ay * 4096;
        if (z > PI_Q24) z -= TWO_PI_Q24;
        if (z < -PI_Q24) z += TWO_PI_Q24;
        if (z > HALF_PI_Q24) begin
            z -= PI_Q24;
            flip = 1;
        end else if (z < -HALF_PI_Q24) begin
            z += PI_Q24;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= longint'(ATAN_TAB[i]);
            end else begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        x = shr_floor(x * INV_GAIN_Q30 + (64'sd1 <<< 41), 42);
        y = shr_floor(y * INV_GAIN_Q30 + (64'sd1 <<< 41), 42);
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (!lim_writeback) begin
            n = n0;
            e = e0;
            u = u0;
        end
        r.pitch   = ANG_W'(clamp_signed(x, ANG_W));
        r.roll    = ANG_W'(clamp_signed(y, ANG_W));
        r.thrust  = FW'(thr);
        r.north   = FW'(clamp_signed(n, FW));
        r.east    = FW'(clamp_signed(e, FW));
        r.up      = FW'(clamp_signed(u, FW));
        r.limited = lim;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, field, got, want);
        error_count++;
    endtask

    // Result checker and receiver stall.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            setpoint_t w;
            if (expected_setpoints.size() == 0) begin
                report_mismatch("unexpected transaction", m_tuser[0], 0);
            end else begin
                w = expected_setpoints.pop_front();
                if (m_tdata[15:0] !== w.pitch) report_mismatch("pitch", m_tdata[15:0], w.pitch);
                if (m_tdata[31:16] !== w.roll) report_mismatch("roll", m_tdata[31:16], w.roll);
                if (m_tdata[51:32] !== w.thrust)
                    report_mismatch("thrust", m_tdata[51:32], w.thrust);
                if (m_tdata[71:52] !== w.north) report_mismatch("north", m_tdata[71:52], w.north);
                if (m_tdata[91:72] !== w.east) report_mismatch("east", m_tdata[91:72], w.east);
                if (m_tdata[111:92] !== w.up) report_mismatch("up", m_tdata[111:92], w.up);
                if (m_tuser[0] !== w.limited) report_mismatch("limited", m_tuser[0], w.limited);
            end
            result_count <= result_count + 1;
        end
        m_tready <= !hold_sink && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, longint unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (FW - 1)'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_THRUST) lim_max = val & ((64'd1 << (FW - 1)) - 1);
        else lim_writeback = val[0];
        @(posedge aclk);
    endtask

    // An unused index must be ignored by both the block and the predictor.
    task automatic write_unused_reg();
        cfg_valid <= 1'b1;
        cfg_index <= 4'hF;
        cfg_data  <= '1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_setpoints.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Sends one transaction; an optional typed expectation replaces the predictor.
    // Valid stays high after the handshake so that the next call can follow without a gap.
    task automatic send_cmd(force_cmd_t c, bit typed = 0, setpoint_t t = '{default: 0});
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDW'(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_setpoints.push_back(typed ? t : predict_setpoint(c));
    endtask

    function automatic force_cmd_t random_cmd();
        force_cmd_t c;
        int k = $urandom_range(9);
        c.north   = FW'($urandom);
        c.east    = FW'($urandom);
        c.up      = FW'($urandom);
        c.heading = HEAD_W'($signed($urandom_range(2 * 12868)) - 12868);
        if (k < 5) begin
            // Flight-like magnitudes.
            c.north = FW'($signed(20'($urandom_range(40000))) - 20000);
            c.east  = FW'($signed(20'($urandom_range(40000))) - 20000);
            c.up    = FW'($signed(20'($urandom_range(60000))) - 4000);
        end else if (k == 6) begin
            c.heading = HEAD_W'($urandom);
        end
        return c;
    endfunction

    typedef struct {
        force_cmd_t cmd;
        bit         typed;
        setpoint_t  want;
    } cmd_row_t;

    cmd_row_t rows[$];
    longint unsigned max_set[5] = '{0, 1000, 2047, 30000, 524287};

    initial begin
        cmd_row_t row;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sink = 0;
        lim_max = 0;
        lim_writeback = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, reset configuration: maximum zero, inputs echoed.
        row.typed = 1;
        row.cmd = '{heading: 0, up: 0, east: 0, north: 0};
        row.want = '{pitch: 0, roll: 0, thrust: 0, north: 0, east: 0, up: 0, limited: 1};
        rows.push_back(row);
        row.cmd = '{heading: 15'sd12868, up: 20'h7FFFF, east: 20'h80000, north: 20'h7FFFF};
        row.want = '{pitch: 0, roll: 0, thrust: 0, north: 20'h7FFFF, east: 20'h80000,
                     up: 20'h7FFFF, limited: 1};
        rows.push_back(row);
        row.cmd = '{heading: -15'sd12868, up: 20'h80000, east: 20'h7FFFF, north: 20'h80000};
        row.want = '{pitch: 0, roll: 0, thrust: 0, north: 20'h80000, east: 20'h7FFFF,
                     up: 20'h80000, limited: 1};
        rows.push_back(row);
        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
        drain();

        write_reg(CFG_MAX_THRUST, 524287);
        write_reg(CFG_RETURN_LIMITED, 1);
        write_unused_reg();
        rows.delete();
        row.typed = 0;
        row.cmd = '{heading: 0, up: 20'sd4096, east: 0, north: 0};          rows.push_back(row);
        row.cmd = '{heading: 15'sd6434, up: 20'sd1024, east: 20'sd800, north: -20'sd900};
        rows.push_back(row);
        row.cmd = '{heading: 15'h3FFF, up: 20'h7FFFF, east: 20'h7FFFF, north: 20'h7FFFF};
        rows.push_back(row);
        row.cmd = '{heading: 15'h4000, up: 20'h80000, east: 20'h80000, north: 20'h80000};
        rows.push_back(row);
        row.cmd = '{heading: -15'sd3000, up: 20'sd524000, east: 0, north: 20'sd100};
        rows.push_back(row);
        row.cmd = '{heading: 15'sd12868, up: 20'sd300000, east: -20'sd300000,
                    north: 20'sd300000};
        rows.push_back(row);
        foreach (rows[i]) send_cmd(rows[i].cmd);
        drain();
        write_reg(CFG_MAX_THRUST, 1000);   // below the up floor
        foreach (rows[i]) send_cmd(rows[i].cmd);
        drain();

        // Random phases across register settings and idling profiles.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(CFG_MAX_THRUST, (ph % 6 == 5) ? $urandom_range(524287) : max_set[ph % 5]);
            write_reg(CFG_RETURN_LIMITED, ph[0]);
            unique case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (ph == 4) begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (400) @(posedge aclk);
                        hold_sink = 0;
                    end
                join_none
            end
            for (int i = 0; i < 120; i++) begin
                send_cmd(random_cmd());
                if (i == 60) begin
                    s_tvalid <= 1'b0;
                    while (expected_setpoints.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        $display("Covered directed extremes and %0d results over 16 random phases,", result_count);
        $display("including long output stalls, idle gaps and several thrust limits.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
